>>> sv/speech_segment_tracker_top_macros.svh
// Assertion macros for the speech segment tracker.
// Included by speech_segment_tracker_top; no other dependencies.
`ifndef SPEECH_SEGMENT_TRACKER_TOP_MACROS_SVH
`define SPEECH_SEGMENT_TRACKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SST_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define SST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SST_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define SST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> sv/sst_pkg.sv
// Package for the speech segment tracker: widths, register indexes,
// reset values, opcodes and shared types. No dependencies.
package sst_pkg;

    localparam int SST_COUNT_BITS  = 32;
    localparam int SST_PROB_BITS   = 16;
    localparam int PROB_FIELD_BITS = 16;
    localparam int LEN_BITS        = 32;
    localparam int WIN_BITS        = 13;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic OP_WINDOW = 1'b0;
    localparam logic OP_EOS    = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HYST_OFFSET = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SPEECH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SILENCE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPEECH  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_SIL   = 3'd6;

    localparam int SPLIT_MS = 98;

    localparam logic [PROB_FIELD_BITS-1:0] THRESHOLD_RESET   = 16'd16384;
    localparam logic [PROB_FIELD_BITS-1:0] HYST_OFFSET_RESET = 16'd4915;
    localparam logic [WIN_BITS-1:0]        WINDOW_RESET      = 13'd512;
    localparam logic [LEN_BITS-1:0]        MIN_SPEECH_RESET  = 32'd4000;
    localparam logic [LEN_BITS-1:0]        MIN_SILENCE_RESET = 32'd1600;
    localparam logic [LEN_BITS-1:0]        MAX_SPEECH_RESET  = '1;
    localparam logic [LEN_BITS-1:0]        SPLIT_SIL_RESET   = LEN_BITS'(16 * SPLIT_MS);

    typedef struct packed {
        logic [PROB_FIELD_BITS-1:0] speech_threshold;
        logic [PROB_FIELD_BITS-1:0] hysteresis_offset;
        logic [WIN_BITS-1:0]        window_samples;
        logic [LEN_BITS-1:0]        min_speech_len;
        logic [LEN_BITS-1:0]        min_silence_len;
        logic [LEN_BITS-1:0]        max_speech_len;
        logic [LEN_BITS-1:0]        split_silence_len;
    } cfg_t;

    typedef struct packed {
        logic in_speech;
        logic start_known;
    } sst_status_t;

endpackage

>>> sv/sst_core.sv
// Segment tracker state and per-item decision logic.
// Depends on sst_pkg.
module sst_core import sst_pkg::*; #(
    parameter int COUNT_BITS = SST_COUNT_BITS,
    parameter int PROB_BITS  = SST_PROB_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       opcode,
    input  logic [PROB_FIELD_BITS-1:0] win_prob,
    input  logic [LEN_BITS-1:0]        stream_length,
    input  cfg_t                       cfg,
    output logic                       emit,
    output logic [LEN_BITS-1:0]        seg_start,
    output logic [LEN_BITS-1:0]        seg_end,
    output sst_status_t                status
);

    localparam int PW = (PROB_BITS < PROB_FIELD_BITS) ? PROB_BITS : PROB_FIELD_BITS;
    localparam int CW = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

    logic                  in_speech_reg, in_speech_next;
    logic                  start_known_reg, start_known_next;
    logic [COUNT_BITS-1:0] sample_pos_reg, sample_pos_next;
    logic [COUNT_BITS-1:0] silence_begin_reg, silence_begin_next;
    logic [COUNT_BITS-1:0] last_split_end_reg, last_split_end_next;
    logic [COUNT_BITS-1:0] resume_start_reg, resume_start_next;
    logic [COUNT_BITS-1:0] open_start_reg, open_start_next;

    logic [COUNT_BITS-1:0] pos_n, span, sb, quiet, seg_len;
    logic [PW-1:0]         prob_m, thr_m, off_m;
    logic signed [PW+1:0]  low_s, prob_s;
    logic                  is_speech, above_low, too_long, split_ok, close_ok, resume;

    assign pos_n     = sample_pos_reg + COUNT_BITS'(cfg.window_samples);
    assign prob_m    = PW'(win_prob);
    assign thr_m     = PW'(cfg.speech_threshold);
    assign off_m     = PW'(cfg.hysteresis_offset);
    assign low_s     = $signed({2'b00, thr_m}) - $signed({2'b00, off_m});
    assign prob_s    = $signed({2'b00, prob_m});
    assign is_speech = prob_m >= thr_m;
    assign above_low = prob_s >= low_s;
    assign span      = pos_n - open_start_reg;
    assign too_long  = in_speech_reg && (CW'(span) > CW'(cfg.max_speech_len));
    assign sb        = (silence_begin_reg == '0) ? pos_n : silence_begin_reg;
    assign quiet     = pos_n - sb;
    assign seg_len   = sb - open_start_reg;
    assign split_ok  = CW'(quiet) > CW'(cfg.split_silence_len);
    assign close_ok  = (CW'(quiet) >= CW'(cfg.min_silence_len))
                    && (CW'(seg_len) > CW'(cfg.min_speech_len));
    assign resume    = !(resume_start_reg < last_split_end_reg);

    always_comb begin
        in_speech_next      = in_speech_reg;
        start_known_next    = start_known_reg;
        sample_pos_next     = sample_pos_reg;
        silence_begin_next  = silence_begin_reg;
        last_split_end_next = last_split_end_reg;
        resume_start_next   = resume_start_reg;
        open_start_next     = open_start_reg;
        emit                = 1'b0;
        seg_start           = LEN_BITS'(open_start_reg);
        seg_end             = LEN_BITS'(last_split_end_reg);
        if (opcode == OP_EOS) begin
            emit                = start_known_reg;
            seg_end             = stream_length;
            in_speech_next      = 1'b0;
            start_known_next    = 1'b0;
            sample_pos_next     = '0;
            silence_begin_next  = '0;
            last_split_end_next = '0;
            resume_start_next   = '0;
            open_start_next     = '0;
        end else begin
            sample_pos_next = pos_n;
            if (is_speech) begin
                if (silence_begin_reg != '0) begin
                    silence_begin_next = '0;
                    if (resume_start_reg < last_split_end_reg) begin
                        resume_start_next = sample_pos_reg;
                    end
                end
                if (!in_speech_reg) begin
                    in_speech_next   = 1'b1;
                    open_start_next  = sample_pos_reg;
                    start_known_next = 1'b1;
                end
            end else if (too_long) begin
                emit                = 1'b1;
                in_speech_next      = 1'b0;
                start_known_next    = 1'b0;
                open_start_next     = '0;
                last_split_end_next = '0;
                resume_start_next   = '0;
                silence_begin_next  = '0;
                if (last_split_end_reg != '0) begin
                    if (resume) begin
                        in_speech_next   = 1'b1;
                        open_start_next  = resume_start_reg;
                        start_known_next = 1'b1;
                    end
                end else begin
                    seg_end = LEN_BITS'(pos_n);
                end
            end else if (!above_low && in_speech_reg) begin
                silence_begin_next = sb;
                if (split_ok) begin
                    last_split_end_next = sb;
                end
                if (close_ok) begin
                    emit                = 1'b1;
                    seg_end             = LEN_BITS'(sb);
                    in_speech_next      = 1'b0;
                    start_known_next    = 1'b0;
                    open_start_next     = '0;
                    last_split_end_next = '0;
                    resume_start_next   = '0;
                    silence_begin_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_speech_reg      <= 1'b0;
            start_known_reg    <= 1'b0;
            sample_pos_reg     <= '0;
            silence_begin_reg  <= '0;
            last_split_end_reg <= '0;
            resume_start_reg   <= '0;
            open_start_reg     <= '0;
        end else if (step) begin
            in_speech_reg      <= in_speech_next;
            start_known_reg    <= start_known_next;
            sample_pos_reg     <= sample_pos_next;
            silence_begin_reg  <= silence_begin_next;
            last_split_end_reg <= last_split_end_next;
            resume_start_reg   <= resume_start_next;
            open_start_reg     <= open_start_next;
        end
    end

    assign status.in_speech   = in_speech_reg;
    assign status.start_known = start_known_reg;

endmodule

>>> sv/speech_segment_tracker_top.sv
// Top level of the speech segment tracker: ports, config registers,
// input and result registers. Depends on sst_pkg, sst_core and the macros header.
//
//  channel | ports            | carries
//  --------+------------------+-------------------------------------------
//  input   | s_valid/s_ready  | opcode, win_prob, stream_length
//  result  | m_valid/m_ready  | segment_start, segment_end (0 or 1 per beat)
//  config  | cfg_valid/ready  | cfg_index, cfg_data (always ready)
//
// From input beat to result: input register, then the tracker
// logic writes state and the result register in one step.
// One beat per cycle sustained; the only stall is a held result register.
// Reset (aresetn low, synchronous) clears tracker state and restores
// register defaults. No clearing pass.
`include "speech_segment_tracker_top_macros.svh"
module speech_segment_tracker_top import sst_pkg::*; #(
    parameter int COUNT_BITS = SST_COUNT_BITS,
    parameter int PROB_BITS  = SST_PROB_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [PROB_FIELD_BITS-1:0] s_win_prob,
    input  logic [LEN_BITS-1:0]        s_stream_length,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LEN_BITS-1:0]        m_segment_start,
    output logic [LEN_BITS-1:0]        m_segment_end,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

    cfg_t                       cfg_reg;
    logic                       in_valid_reg, in_valid_next;
    logic                       in_opcode_reg;
    logic [PROB_FIELD_BITS-1:0] in_prob_reg;
    logic [LEN_BITS-1:0]        in_len_reg;
    logic                       m_valid_reg, m_valid_next;
    logic [LEN_BITS-1:0]        m_start_reg, m_end_reg;
    logic                       item_adv, s_beat;
    logic                       core_emit;
    logic [LEN_BITS-1:0]        core_start, core_end;
    sst_status_t                core_status;

    assign item_adv  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || item_adv;
    assign s_beat    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat) begin
            in_valid_next = 1'b1;
        end else if (item_adv) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (item_adv) begin
            m_valid_next = core_emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_opcode_reg <= s_opcode;
            in_prob_reg   <= s_win_prob;
            in_len_reg    <= s_stream_length;
        end
        if (item_adv && core_emit) begin
            m_start_reg <= core_start;
            m_end_reg   <= core_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speech_threshold  <= THRESHOLD_RESET;
            cfg_reg.hysteresis_offset <= HYST_OFFSET_RESET;
            cfg_reg.window_samples    <= WINDOW_RESET;
            cfg_reg.min_speech_len    <= MIN_SPEECH_RESET;
            cfg_reg.min_silence_len   <= MIN_SILENCE_RESET;
            cfg_reg.max_speech_len    <= MAX_SPEECH_RESET;
            cfg_reg.split_silence_len <= SPLIT_SIL_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD: begin
                    cfg_reg.speech_threshold <= cfg_data[PROB_FIELD_BITS-1:0];
                end
                REG_HYST_OFFSET: begin
                    cfg_reg.hysteresis_offset <= cfg_data[PROB_FIELD_BITS-1:0];
                end
                REG_WINDOW: begin
                    cfg_reg.window_samples <= cfg_data[WIN_BITS-1:0];
                end
                REG_MIN_SPEECH: begin
                    cfg_reg.min_speech_len <= cfg_data[LEN_BITS-1:0];
                end
                REG_MIN_SILENCE: begin
                    cfg_reg.min_silence_len <= cfg_data[LEN_BITS-1:0];
                end
                REG_MAX_SPEECH: begin
                    cfg_reg.max_speech_len <= cfg_data[LEN_BITS-1:0];
                end
                REG_SPLIT_SIL: begin
                    cfg_reg.split_silence_len <= cfg_data[LEN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sst_core #(
        .COUNT_BITS (COUNT_BITS),
        .PROB_BITS  (PROB_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (item_adv),
        .opcode        (in_opcode_reg),
        .win_prob      (in_prob_reg),
        .stream_length (in_len_reg),
        .cfg           (cfg_reg),
        .emit          (core_emit),
        .seg_start     (core_start),
        .seg_end       (core_end),
        .status        (core_status)
    );

    assign m_valid         = m_valid_reg;
    assign m_segment_start = m_start_reg;
    assign m_segment_end   = m_end_reg;

    `SST_ASSERT_IMPLIES(a_speech_has_start, aclk, aresetn, core_status.in_speech, core_status.start_known, "in speech without a start")
    `SST_ASSERT_NEXT(a_eos_clears, aclk, aresetn, item_adv && (in_opcode_reg == OP_EOS), !core_status.in_speech && !core_status.start_known, "end of stream left a segment open")
    `SST_ASSERT_NEXT(a_stall_holds_item, aclk, aresetn, in_valid_reg && !item_adv, in_valid_reg, "pending beat dropped")
    `SST_ASSERT_NEXT(a_result_source, aclk, aresetn, !m_valid_reg, !m_valid_reg || $past(item_adv && core_emit), "result without an emitting beat")

endmodule
